>>> sv/bgm_pkg.sv
package bgm_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int DIM_W       = 13;
   localparam int POS_W       = 12;
   localparam int CHAN_W      = 8;
   localparam int NUM_LANES   = 4;
   localparam int NUM_CORNERS = 4;

   // corner value times a coordinate stays at or below 255 * MAX_DIM
   localparam int PROD_W = 20;
   // blend numerator stays at or below 255 * MAX_DIM * MAX_DIM
   localparam int NUM_W  = 32;
   localparam int DEN_W  = 2 * DIM_W - 1;
   localparam int QUO_W  = CHAN_W;

   localparam int DATA_W    = 32;
   localparam int REG_IDX_W = 3;
   localparam int ADDR_W    = REG_IDX_W + 2;

   localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CORNER_0     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CORNER_1     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CORNER_2     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_CORNER_3     = 3'd5;

   localparam logic [DIM_W-1:0]  DIM_RESET    = 13'd256;
   localparam logic [DATA_W-1:0] CORNER_RESET = 32'hFFFF_FFFF;

   typedef logic [NUM_LANES-1:0][CHAN_W-1:0] pixel_type;
   typedef logic [NUM_LANES-1:0][QUO_W-1:0]  weight_type;
   typedef logic [NUM_LANES-1:0][NUM_W-1:0]  numer_type;

   typedef struct packed {
      logic      clamped;
      pixel_type px;
   } side_type;

   typedef struct packed {
      logic [DIM_W-1:0]                                 width;
      logic [DIM_W-1:0]                                 height;
      logic [DEN_W-1:0]                                 denom;
      logic [NUM_CORNERS-1:0][NUM_LANES-1:0][CHAN_W-1:0] corner;
   } cfg_type;

endpackage

>>> sv/bgm_if.sv
interface bgm_req_if import bgm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  pos_x;
   logic [POS_W-1:0]  pos_y;
   logic [CHAN_W-1:0] in_red;
   logic [CHAN_W-1:0] in_green;
   logic [CHAN_W-1:0] in_blue;
   logic [CHAN_W-1:0] in_alpha;

   modport source (output valid, pos_x, pos_y, in_red, in_green, in_blue, in_alpha,
                   input ready);
   modport sink (input valid, pos_x, pos_y, in_red, in_green, in_blue, in_alpha,
                 output ready);
endinterface

interface bgm_rsp_if import bgm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] out_red;
   logic [CHAN_W-1:0] out_green;
   logic [CHAN_W-1:0] out_blue;
   logic [CHAN_W-1:0] out_alpha;
   logic              coord_clamped;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, coord_clamped,
                   input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha, coord_clamped,
                 output ready);
endinterface

>>> sv/bgm_csr.sv
module bgm_csr import bgm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output cfg_type           cfg
);

   logic [DIM_W-1:0]                    width_ff, width_in;
   logic [DIM_W-1:0]                    height_ff, height_in;
   logic [NUM_CORNERS-1:0][DATA_W-1:0] corner_ff, corner_in;
   logic [DEN_W-1:0]                    denom_ff, denom_in;
   logic [REG_IDX_W-1:0]                index;
   logic                                wr_en;
   logic [DIM_W-1:0]                    eff_w, eff_h;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw);
      logic [DIM_W-1:0] v;
      v = raw;
      if (raw == '0) begin
         v = DIM_W'(1);
      end else if (raw > DIM_W'(MAX_DIM)) begin
         v = DIM_W'(MAX_DIM);
      end
      return v;
   endfunction

   assign index = paddr[ADDR_W-1:2];
   assign wr_en = psel & penable & pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      corner_in = corner_ff;
      if (wr_en) begin
         case (index)
            REG_FRAME_WIDTH: begin
               width_in = pwdata[DIM_W-1:0];
            end
            REG_FRAME_HEIGHT: begin
               height_in = pwdata[DIM_W-1:0];
            end
            REG_CORNER_0: begin
               corner_in[0] = pwdata;
            end
            REG_CORNER_1: begin
               corner_in[1] = pwdata;
            end
            REG_CORNER_2: begin
               corner_in[2] = pwdata;
            end
            REG_CORNER_3: begin
               corner_in[3] = pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign eff_w    = eff_dim(width_ff);
   assign eff_h    = eff_dim(height_ff);
   // denominator is needed only deep in the pipe, so it can take a register
   assign denom_in = DEN_W'(eff_w) * DEN_W'(eff_h);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
         corner_ff <= {NUM_CORNERS{CORNER_RESET}};
         denom_ff  <= DEN_W'(DIM_RESET) * DEN_W'(DIM_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         corner_ff <= corner_in;
         denom_ff  <= denom_in;
      end
   end

   always_comb begin
      case (index)
         REG_FRAME_WIDTH: begin
            prdata = DATA_W'(width_ff);
         end
         REG_FRAME_HEIGHT: begin
            prdata = DATA_W'(height_ff);
         end
         REG_CORNER_0: begin
            prdata = corner_ff[0];
         end
         REG_CORNER_1: begin
            prdata = corner_ff[1];
         end
         REG_CORNER_2: begin
            prdata = corner_ff[2];
         end
         REG_CORNER_3: begin
            prdata = corner_ff[3];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_comb begin
      cfg.width  = eff_w;
      cfg.height = eff_h;
      cfg.denom  = denom_ff;
      for (int c = 0; c < NUM_CORNERS; c++) begin
         cfg.corner[c] = corner_ff[c];
      end
   end

endmodule

>>> sv/bgm_numer.sv
module bgm_numer import bgm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [POS_W-1:0] in_x,
   input  logic [POS_W-1:0] in_y,
   input  side_type         in_side,
   output logic             out_valid,
   input  logic             out_ready,
   output numer_type        out_num,
   output side_type         out_side
);

   localparam int NSTG = 5;

   logic [NSTG-1:0]           v_ff, v_in, en;
   side_type [NSTG-1:0]       side_ff, side_in;

   logic [POS_W-1:0]          x1_ff, x1_in, y1_ff, y1_in;
   logic [DIM_W-1:0]          wx1_ff, wx1_in, hy1_ff, hy1_in;

   logic [NUM_LANES-1:0][PROD_W-1:0] c2y_ff, c2y_in, c0h_ff, c0h_in;
   logic [NUM_LANES-1:0][PROD_W-1:0] c3y_ff, c3y_in, c1h_ff, c1h_in;
   logic [POS_W-1:0]          x2_ff;
   logic [DIM_W-1:0]          wx2_ff;

   logic [NUM_LANES-1:0][PROD_W-1:0] left_ff, left_in, right_ff, right_in;
   logic [POS_W-1:0]          x3_ff;
   logic [DIM_W-1:0]          wx3_ff;

   numer_type                 lx_ff, lx_in, rw_ff, rw_in;
   numer_type                 num_ff, num_in;

   logic [DIM_W-1:0]          x_ext, y_ext, w_last, h_last;
   logic                      x_clip, y_clip;

   // a stage loads when it is empty or its successor moves on
   always_comb begin
      en[NSTG-1] = ~v_ff[NSTG-1] | out_ready;
      for (int s = NSTG - 2; s >= 0; s--) begin
         en[s] = ~v_ff[s] | en[s+1];
      end
   end

   assign in_ready  = en[0];
   assign v_in      = {v_ff[NSTG-2:0], in_valid};
   assign out_valid = v_ff[NSTG-1];
   assign out_num   = num_ff;
   assign out_side  = side_ff[NSTG-1];

   // stage 1: clamp the position, form the complementary distances
   always_comb begin
      x_ext  = {1'b0, in_x};
      y_ext  = {1'b0, in_y};
      w_last = cfg.width - DIM_W'(1);
      h_last = cfg.height - DIM_W'(1);
      x_clip = x_ext >= cfg.width;
      y_clip = y_ext >= cfg.height;
      x1_in  = x_clip ? w_last[POS_W-1:0] : in_x;
      y1_in  = y_clip ? h_last[POS_W-1:0] : in_y;
      wx1_in = x_clip ? DIM_W'(1) : cfg.width - x_ext;
      hy1_in = y_clip ? DIM_W'(1) : cfg.height - y_ext;
      side_in[0]         = in_side;
      side_in[0].clamped = x_clip | y_clip;
      for (int s = 1; s < NSTG; s++) begin
         side_in[s] = side_ff[s-1];
      end
   end

   // stages 2 to 5: vertical products, vertical sums, horizontal products, final sum
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         c2y_in[l]   = PROD_W'(cfg.corner[2][l]) * PROD_W'(y1_ff);
         c0h_in[l]   = PROD_W'(cfg.corner[0][l]) * PROD_W'(hy1_ff);
         c3y_in[l]   = PROD_W'(cfg.corner[3][l]) * PROD_W'(y1_ff);
         c1h_in[l]   = PROD_W'(cfg.corner[1][l]) * PROD_W'(hy1_ff);
         left_in[l]  = c2y_ff[l] + c0h_ff[l];
         right_in[l] = c3y_ff[l] + c1h_ff[l];
         lx_in[l]    = NUM_W'(left_ff[l]) * NUM_W'(x3_ff);
         rw_in[l]    = NUM_W'(right_ff[l]) * NUM_W'(wx3_ff);
         num_in[l]   = lx_ff[l] + rw_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < NSTG; s++) begin
            if (en[s]) begin
               v_ff[s] <= v_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NSTG; s++) begin
         if (en[s]) begin
            side_ff[s] <= side_in[s];
         end
      end
      if (en[0]) begin
         x1_ff  <= x1_in;
         y1_ff  <= y1_in;
         wx1_ff <= wx1_in;
         hy1_ff <= hy1_in;
      end
      if (en[1]) begin
         c2y_ff <= c2y_in;
         c0h_ff <= c0h_in;
         c3y_ff <= c3y_in;
         c1h_ff <= c1h_in;
         x2_ff  <= x1_ff;
         wx2_ff <= wx1_ff;
      end
      if (en[2]) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         x3_ff    <= x2_ff;
         wx3_ff   <= wx2_ff;
      end
      if (en[3]) begin
         lx_ff <= lx_in;
         rw_ff <= rw_in;
      end
      if (en[4]) begin
         num_ff <= num_in;
      end
   end

endmodule

>>> sv/bgm_div.sv
module bgm_div import bgm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [DEN_W-1:0] denom,
   input  logic             in_valid,
   output logic             in_ready,
   input  numer_type        in_num,
   input  side_type         in_side,
   output logic             out_valid,
   input  logic             out_ready,
   output weight_type       out_wt,
   output side_type         out_side
);

   // one quotient bit per stage, most significant first
   localparam int STAGES = QUO_W;

   logic [STAGES-1:0]              v_ff, v_in, en;
   side_type [STAGES-1:0]          side_ff, side_in;
   numer_type [STAGES-1:0]         rem_ff, rem_in, rem_src;
   weight_type [STAGES-1:0]        q_ff, q_in, q_src;

   always_comb begin
      en[STAGES-1] = ~v_ff[STAGES-1] | out_ready;
      for (int s = STAGES - 2; s >= 0; s--) begin
         en[s] = ~v_ff[s] | en[s+1];
      end
   end

   assign in_ready  = en[0];
   assign v_in      = {v_ff[STAGES-2:0], in_valid};
   assign out_valid = v_ff[STAGES-1];
   assign out_wt    = q_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

   always_comb begin : restore_step
      logic [NUM_W-1:0] dsh;
      logic [NUM_W:0]   diff;
      rem_src[0] = in_num;
      q_src[0]   = '0;
      side_in[0] = in_side;
      for (int s = 1; s < STAGES; s++) begin
         rem_src[s] = rem_ff[s-1];
         q_src[s]   = q_ff[s-1];
         side_in[s] = side_ff[s-1];
      end
      for (int s = 0; s < STAGES; s++) begin
         dsh = NUM_W'(denom) << (QUO_W - 1 - s);
         for (int l = 0; l < NUM_LANES; l++) begin
            diff        = {1'b0, rem_src[s][l]} - {1'b0, dsh};
            q_in[s][l]  = q_src[s][l];
            q_in[s][l][QUO_W-1-s] = ~diff[NUM_W];
            // keep the remainder when the trial subtract goes negative
            rem_in[s][l] = diff[NUM_W] ? rem_src[s][l] : diff[NUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (en[s]) begin
               v_ff[s] <= v_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (en[s]) begin
            rem_ff[s]  <= rem_in[s];
            q_ff[s]    <= q_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

endmodule

>>> sv/bgm_scale.sv
module bgm_scale import bgm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  weight_type in_wt,
   input  side_type   in_side,
   output logic       out_valid,
   input  logic       out_ready,
   output pixel_type  out_pixel,
   output logic       out_clamped
);

   localparam int DBL_W = 2 * CHAN_W;

   logic [1:0]                       v_ff, v_in, en;
   logic [NUM_LANES-1:0][DBL_W-1:0] prod_ff, prod_in;
   logic                             cl1_ff, cl2_ff;
   pixel_type                        pix_ff, pix_in;
   logic [NUM_LANES-1:0][DBL_W-1:0] fold;

   assign en[1]    = ~v_ff[1] | out_ready;
   assign en[0]    = ~v_ff[0] | en[1];
   assign in_ready = en[0];
   assign v_in     = {v_ff[0], in_valid};

   assign out_valid   = v_ff[1];
   assign out_pixel   = pix_ff;
   assign out_clamped = cl2_ff;

   // floor(p / 255) for p up to 255 * 255 is (p + (p >> 8) + 1) >> 8
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         prod_in[l] = DBL_W'(in_side.px[l]) * DBL_W'(in_wt[l]);
         fold[l]    = prod_ff[l] + (prod_ff[l] >> CHAN_W) + DBL_W'(1);
         pix_in[l]  = fold[l][DBL_W-1:CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= v_in[0];
         end
         if (en[1]) begin
            v_ff[1] <= v_in[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
         cl1_ff  <= in_side.clamped;
      end
      if (en[1]) begin
         pix_ff <= pix_in;
         cl2_ff <= cl1_ff;
      end
   end

endmodule

>>> sv/bilinear_gradient_modulator_top.sv
// Channel  Port        Kind            Content
// -------  ----------  --------------  ------------------------------------------
// request  req_bus     valid/ready     pos_x, pos_y, in_red/green/blue/alpha
// result   rsp_bus     valid/ready     out_red/green/blue/alpha, coord_clamped
// config   csr_*       APB-style       frame_width, frame_height, corner_color_0..3
//
// One transaction per cycle is accepted and one result leaves per cycle while the result
// side is ready. Stages: 5 blend, 8 divider (one quotient bit each) and 2 scale stages.
// Reset clears the valid bit of every stage and loads the register reset values.
// Each stage holds while its successor is full and stalled, so an empty stage still
// fills behind a held result; ready is low only when every stage is occupied.
module bilinear_gradient_modulator_top import bgm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   bgm_req_if.sink           req_bus,
   bgm_rsp_if.source         rsp_bus,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type    cfg;
   side_type   req_side, num_side, div_side;
   numer_type  num_data;
   weight_type div_wt;
   pixel_type  out_pixel;
   logic       num_valid, num_ready, div_valid, div_ready;
   logic       rsp_valid, req_ready, out_clamped;

   assign csr_pready = 1'b1;

   bgm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   always_comb begin
      req_side.clamped = 1'b0;
      req_side.px[0]   = req_bus.in_red;
      req_side.px[1]   = req_bus.in_green;
      req_side.px[2]   = req_bus.in_blue;
      req_side.px[3]   = req_bus.in_alpha;
   end

   assign req_bus.ready = req_ready;

   bgm_numer u_numer (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_bus.valid),
      .in_ready  (req_ready),
      .in_x      (req_bus.pos_x),
      .in_y      (req_bus.pos_y),
      .in_side   (req_side),
      .out_valid (num_valid),
      .out_ready (num_ready),
      .out_num   (num_data),
      .out_side  (num_side)
   );

   bgm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .denom     (cfg.denom),
      .in_valid  (num_valid),
      .in_ready  (num_ready),
      .in_num    (num_data),
      .in_side   (num_side),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_wt    (div_wt),
      .out_side  (div_side)
   );

   bgm_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (div_valid),
      .in_ready    (div_ready),
      .in_wt       (div_wt),
      .in_side     (div_side),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_bus.ready),
      .out_pixel   (out_pixel),
      .out_clamped (out_clamped)
   );

   assign rsp_bus.valid         = rsp_valid;
   assign rsp_bus.out_red       = out_pixel[0];
   assign rsp_bus.out_green     = out_pixel[1];
   assign rsp_bus.out_blue      = out_pixel[2];
   assign rsp_bus.out_alpha     = out_pixel[3];
   assign rsp_bus.coord_clamped = out_clamped;

endmodule

>>> verif/bilinear_gradient_modulator_top_test.sv
`timescale 1ns / 1ps

module bilinear_gradient_modulator_top_test;
   import bgm_pkg::*;

   localparam int CYCLE_LIMIT     = 100000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int IDLE_PERCENT    = 29;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_PIXELS    = 166;
   localparam int MAX_REPORTS     = 10;

   // decoded but unmapped register slots
   localparam logic [REG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      pixel_type        px;
   } pixel_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   bgm_req_if req_bus ();
   bgm_rsp_if rsp_bus ();

   bilinear_gradient_modulator_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // shadow of the register file
   logic [DIM_W-1:0]  frame_w;
   logic [DIM_W-1:0]  frame_h;
   logic [DATA_W-1:0] corner [NUM_CORNERS];

   pixel_item_type pixel_q [$];
   side_type    modulated_q [$];
   int          pixels_queued   = 0;
   int          pixels_accepted = 0;
   int          mismatches      = 0;
   int          cycle_count     = 0;
   bit          req_taken       = 1'b0;
   bit          steady          = 1'b0;
   int          holds_requested = 0;
   int          holds_served    = 0;
   int          hold_left       = 0;

   function automatic int unsigned effective_dim(input logic [DIM_W-1:0] dim);
      if (dim == '0)
         return 1;
      if (dim > MAX_DIM)
         return MAX_DIM;
      return dim;
   endfunction

   function automatic side_type modulate_pixel(input logic [POS_W-1:0] pos_x,
                                               input logic [POS_W-1:0] pos_y,
                                               input pixel_type px_in);
      longint unsigned w, h, x, y, den, left, right, wt;
      longint unsigned c0, c1, c2, c3;
      side_type res;
      int k;
      w = effective_dim(frame_w);
      h = effective_dim(frame_h);
      x = pos_x;
      y = pos_y;
      res.clamped = 1'b0;
      if (x >= w) begin
         x = w - 1;
         res.clamped = 1'b1;
      end
      if (y >= h) begin
         y = h - 1;
         res.clamped = 1'b1;
      end
      den = w * h;
      for (k = 0; k < NUM_LANES; k++) begin
         c0 = corner[0][8*k +: 8];
         c1 = corner[1][8*k +: 8];
         c2 = corner[2][8*k +: 8];
         c3 = corner[3][8*k +: 8];
         left  = c2 * y + c0 * (h - y);
         right = c3 * y + c1 * (h - y);
         wt    = (left * x + right * (w - x)) / den;
         res.px[k] = CHAN_W'((longint'(px_in[k]) * wt) / 255);
      end
      return res;
   endfunction

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_FRAME_WIDTH:  frame_w = value[DIM_W-1:0];
         REG_FRAME_HEIGHT: frame_h = value[DIM_W-1:0];
         REG_CORNER_0:     corner[0] = value;
         REG_CORNER_1:     corner[1] = value;
         REG_CORNER_2:     corner[2] = value;
         REG_CORNER_3:     corner[3] = value;
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [DATA_W-1:0] k0, input logic [DATA_W-1:0] k1,
                                input logic [DATA_W-1:0] k2, input logic [DATA_W-1:0] k3);
      csr_write(REG_FRAME_WIDTH, DATA_W'(w));
      csr_write(REG_FRAME_HEIGHT, DATA_W'(h));
      csr_write(REG_CORNER_0, k0);
      csr_write(REG_CORNER_1, k1);
      csr_write(REG_CORNER_2, k2);
      csr_write(REG_CORNER_3, k3);
   endtask

   task automatic queue_pixel(input int x, input int y, input int r, input int g,
                              input int b, input int a);
      pixel_item_type it;
      it.pos_x = POS_W'(x);
      it.pos_y = POS_W'(y);
      it.px    = {CHAN_W'(a), CHAN_W'(b), CHAN_W'(g), CHAN_W'(r)};
      pixel_q.push_back(it);
      pixels_queued++;
   endtask

   function automatic int random_chan();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic int random_pos(input int unsigned dim);
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(0, dim - 1);
      return $urandom_range(0, 4095);
   endfunction

   function automatic logic [DATA_W-1:0] random_corner();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // wait until every queued transaction was accepted and answered
   task automatic drain();
      while (pixels_accepted != pixels_queued || modulated_q.size() != 0)
         @(negedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      pixel_item_type it;
      if (!reset && (!req_bus.valid || req_taken)) begin
         if (pixel_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            it = pixel_q.pop_front();
            req_bus.valid    <= 1'b1;
            req_bus.pos_x    <= it.pos_x;
            req_bus.pos_y    <= it.pos_y;
            req_bus.in_red   <= it.px[0];
            req_bus.in_green <= it.px[1];
            req_bus.in_blue  <= it.px[2];
            req_bus.in_alpha <= it.px[3];
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result receiver; a requested hold keeps ready low for a long stretch
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (holds_served != holds_requested) begin
         holds_served++;
         hold_left = RSP_HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // monitor: predict on request acceptance, compare on result acceptance
   always @(posedge clock) begin
      side_type exp_res;
      side_type got;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         req_taken = !reset && req_bus.valid && req_bus.ready;
         if (req_taken) begin
            modulated_q.push_back(modulate_pixel(req_bus.pos_x, req_bus.pos_y,
               {req_bus.in_alpha, req_bus.in_blue, req_bus.in_green, req_bus.in_red}));
            pixels_accepted++;
         end
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.clamped = rsp_bus.coord_clamped;
            got.px = {rsp_bus.out_alpha, rsp_bus.out_blue, rsp_bus.out_green, rsp_bus.out_red};
            if (modulated_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result at cycle %0d: r=%0d g=%0d b=%0d a=%0d clamp=%0b",
                           cycle_count, got.px[0], got.px[1], got.px[2], got.px[3],
                           got.clamped);
            end else begin
               exp_res = modulated_q.pop_front();
               if (got.px[0] !== exp_res.px[0] || got.px[1] !== exp_res.px[1] ||
                   got.px[2] !== exp_res.px[2] || got.px[3] !== exp_res.px[3] ||
                   got.clamped !== exp_res.clamped) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch at cycle %0d: expected r=%0d g=%0d b=%0d a=%0d",
                              cycle_count, exp_res.px[0], exp_res.px[1], exp_res.px[2],
                              exp_res.px[3], " clamp=%0b, got r=%0d g=%0d b=%0d a=%0d",
                              exp_res.clamped, got.px[0], got.px[1], got.px[2],
                              got.px[3], " clamp=%0b", got.clamped);
               end
            end
         end
      end
   end

   initial begin
      int ph;
      int unsigned w_eff;
      int unsigned h_eff;
      logic [DIM_W-1:0] w_set;
      logic [DIM_W-1:0] h_set;

      req_bus.valid    = 1'b0;
      req_bus.pos_x    = '0;
      req_bus.pos_y    = '0;
      req_bus.in_red   = '0;
      req_bus.in_green = '0;
      req_bus.in_blue  = '0;
      req_bus.in_alpha = '0;
      rsp_bus.ready    = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      frame_w          = DIM_RESET;
      frame_h          = DIM_RESET;
      for (int i = 0; i < NUM_CORNERS; i++)
         corner[i] = CORNER_RESET;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: inside, at the edge, clamped on either axis and both
      queue_pixel(0, 0, 255, 255, 255, 255);
      queue_pixel(255, 255, 255, 255, 255, 255);
      queue_pixel(256, 0, 200, 100, 50, 1);
      queue_pixel(0, 256, 1, 2, 3, 4);
      queue_pixel(4095, 4095, 0, 0, 0, 0);
      queue_pixel(128, 64, 8'h01, 8'h80, 8'hFE, 8'h7F);
      drain();

      // zero width acts as one, oversized height saturates; unmapped slots ignored
      apply_setting(13'd0, 13'h1FFF, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'h1234_5678, 32'hA5C3_0FF0);
      csr_write(REG_UNUSED_6, $urandom());
      csr_write(REG_UNUSED_7, $urandom());
      queue_pixel(0, 0, 255, 255, 255, 255);
      queue_pixel(1, 4095, 255, 128, 64, 32);
      queue_pixel(4095, 2048, 17, 255, 0, 99);
      queue_pixel(0, 4095, 255, 255, 255, 255);
      drain();

      // largest frame, opposing corners
      apply_setting(13'd4096, 13'd4096, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'h0000_0000);
      queue_pixel(0, 0, 255, 255, 255, 255);
      queue_pixel(4095, 4095, 255, 255, 255, 255);
      queue_pixel(0, 4095, 255, 255, 255, 255);
      queue_pixel(4095, 0, 255, 255, 255, 255);
      queue_pixel(2048, 2048, 255, 127, 3, 254);
      drain();

      // single-pixel frame
      apply_setting(13'd1, 13'd1, $urandom(), $urandom(), $urandom(), $urandom());
      queue_pixel(0, 0, 255, 255, 255, 255);
      queue_pixel(1, 0, 90, 180, 45, 255);
      queue_pixel(0, 1, 255, 0, 255, 0);
      drain();

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin w_set = 13'd4096; h_set = 13'd4096; end
            1: begin
               w_set = DIM_W'($urandom_range(1, 16));
               h_set = DIM_W'($urandom_range(1, 16));
            end
            2: begin
               w_set = DIM_W'($urandom_range(0, 8191));
               h_set = DIM_W'($urandom_range(0, 8191));
            end
            3: begin
               w_set = DIM_W'($urandom_range(4097, 8191));
               h_set = DIM_W'($urandom_range(1, 64));
            end
            default: begin
               w_set = DIM_W'($urandom_range(1, 512));
               h_set = DIM_W'($urandom_range(1, 512));
            end
         endcase
         apply_setting(w_set, h_set, random_corner(), random_corner(),
                       random_corner(), random_corner());
         w_eff = effective_dim(frame_w);
         h_eff = effective_dim(frame_h);
         steady = (ph == 4);
         // stall the result side long enough to back up the whole pipeline
         if (ph == 6)
            holds_requested++;
         repeat (PHASE_PIXELS)
            queue_pixel(random_pos(w_eff), random_pos(h_eff), random_chan(), random_chan(),
                        random_chan(), random_chan());
         drain();
         steady = 1'b0;
      end

      repeat (20) @(negedge clock);
      mismatches += modulated_q.size();
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
